FILE: design/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

    // Default size of the owner map in blocks.
    localparam int DEF_TOTAL_BLOCKS = 1024;

    // Owner id that marks a block as free.
    localparam logic [15:0] FREE_MARK = 16'hFFFF;

    // Reset value of the user base register.
    localparam logic [9:0] USER_BASE_RST = 10'd64;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // Operation codes carried in tuser.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_FREE,
        ST_DONE
    } ffba_state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic fill;
        logic free_step;
        logic push;
    } ffba_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic bad;
        logic scan_hit;
        logic scan_miss;
        logic fill_last;
        logic out_free;
    } ffba_status_t;

endpackage

`default_nettype wire

FILE: design/ffba_ctrl.sv
`default_nettype none

module ffba_ctrl
    import ffba_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_func,
    output logic              in_ready,
    input  wire ffba_status_t status,
    output ffba_cmd_t         cmd
);

    ffba_state_t state_reg;
    ffba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_func == FUNC_FREE) ? ST_FREE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.bad || status.scan_miss)
                begin
                    state_next = ST_DONE;
                end
                else if (status.scan_hit)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FREE:
            begin
                // The fill_last flag also marks the last block of a release.
                if (status.bad || status.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = !status.bad;
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
            end
            ST_FREE:
            begin
                cmd.free_step = !status.bad;
            end
            ST_DONE:
            begin
                cmd.push = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/ffba_datapath.sv
`default_nettype none

module ffba_datapath
    import ffba_pkg::*;
#(
    parameter int TOTAL_BLOCKS = DEF_TOTAL_BLOCKS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [9:0]            cfg_wdata,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire logic                  in_func,
    input  wire ffba_cmd_t             cmd,
    output ffba_status_t               status,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_DATA_W-1:0]      out_data
);

    localparam int AW = $clog2(TOTAL_BLOCKS);
    // Wide enough for a block address up to TOTAL_BLOCKS and for start plus count.
    localparam int XW = (AW + 1 > 12) ? AW + 1 : 12;
    localparam logic [XW-1:0] TOTAL_X = XW'(TOTAL_BLOCKS);
    localparam logic [XW-1:0] LAST_X  = XW'(TOTAL_BLOCKS - 1);

    logic [15:0] mem [0:TOTAL_BLOCKS-1];

    logic [15:0]   rd_data_reg;
    logic          mem_we;
    logic [15:0]   mem_wdata;

    logic [9:0]    user_base_reg;
    logic [9:0]    user_base_next;
    logic [XW-1:0] addr_reg;
    logic [XW-1:0] addr_next;
    logic          chk_valid_reg;
    logic          chk_valid_next;
    logic [AW-1:0] chk_addr_reg;
    logic [AW-1:0] chk_addr_next;
    logic [10:0]   run_reg;
    logic [10:0]   run_next;
    logic [AW-1:0] first_reg;
    logic [AW-1:0] first_next;
    logic [AW-1:0] last_reg;
    logic [AW-1:0] last_next;
    logic          bad_reg;
    logic          bad_next;
    logic [15:0]   owner_reg;
    logic [15:0]   owner_next;
    logic [10:0]   count_reg;
    logic [10:0]   count_next;
    logic          res_ok_reg;
    logic          res_ok_next;
    logic [9:0]    res_start_reg;
    logic [9:0]    res_start_next;
    logic          m_valid_reg;
    logic          m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_DATA_W-1:0] m_data_next;

    // Request fields, lowest bits first: owner, real-time, count, has_block, start.
    logic [15:0]   in_owner;
    logic          in_rt;
    logic [10:0]   in_count;
    logic          in_has;
    logic [9:0]    in_start;

    logic [XW-1:0] count_x;
    logic [XW-1:0] start_x;
    logic [XW-1:0] base_x;
    logic [XW-1:0] sum_x;
    logic [XW-1:0] end_x;
    logic [XW-1:0] free_last_x;

    logic          chk_free;
    logic [11:0]   run_inc;
    logic          hit;
    logic [AW-1:0] hit_first;
    logic          out_free;

    assign in_owner = in_data[15:0];
    assign in_rt    = in_data[16];
    assign in_count = in_data[27:17];
    assign in_has   = in_data[28];
    assign in_start = in_data[38:29];

    assign count_x     = XW'(in_count);
    assign start_x     = XW'(in_start);
    assign base_x      = in_rt ? '0 : XW'(user_base_reg);
    assign sum_x       = start_x + count_x;
    assign end_x       = (sum_x > TOTAL_X) ? TOTAL_X : sum_x;
    assign free_last_x = end_x - XW'(1);

    assign chk_free  = (rd_data_reg == FREE_MARK);
    assign run_inc   = {1'b0, run_reg} + 12'd1;
    assign hit       = chk_valid_reg && chk_free && (run_inc == {1'b0, count_reg});
    assign hit_first = (run_reg == 11'd0) ? chk_addr_reg : first_reg;
    assign out_free  = !m_valid_reg || out_ready;

    assign status.clear_last = (addr_reg == LAST_X);
    assign status.bad        = bad_reg;
    assign status.scan_hit   = hit;
    assign status.scan_miss  = !chk_valid_reg && (addr_reg >= TOTAL_X);
    assign status.fill_last  = (addr_reg[AW-1:0] == last_reg);
    assign status.out_free   = out_free;

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;

    // Owner map: one write port, one registered read port.
    always_comb
    begin
        mem_we    = cmd.clear || cmd.fill || cmd.free_step;
        mem_wdata = cmd.fill ? owner_reg : FREE_MARK;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg[AW-1:0]] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg[AW-1:0]];
    end

    always_comb
    begin
        user_base_next = user_base_reg;
        addr_next      = addr_reg;
        chk_valid_next = chk_valid_reg;
        chk_addr_next  = chk_addr_reg;
        run_next       = run_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        owner_next     = owner_reg;
        count_next     = count_reg;
        res_ok_next    = res_ok_reg;
        res_start_next = res_start_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (cfg_we)
        begin
            user_base_next = cfg_wdata;
        end

        if (cmd.load)
        begin
            owner_next     = in_owner;
            count_next     = in_count;
            run_next       = '0;
            chk_valid_next = 1'b0;
            res_ok_next    = 1'b0;
            res_start_next = '0;
            if (in_func == FUNC_FREE)
            begin
                addr_next = start_x;
                last_next = free_last_x[AW-1:0];
                bad_next  = !in_has || (start_x >= TOTAL_X) || (in_count == 11'd0);
            end
            else
            begin
                addr_next = base_x;
                bad_next  = (in_count == 11'd0) || (count_x > TOTAL_X);
            end
        end

        if (cmd.clear || cmd.fill || cmd.free_step)
        begin
            addr_next = addr_reg + XW'(1);
        end

        if (cmd.free_step)
        begin
            res_ok_next = 1'b1;
        end

        if (cmd.scan)
        begin
            // Reads are issued one block per cycle; the check stage takes the registered read data.
            if (addr_reg < TOTAL_X)
            begin
                chk_valid_next = 1'b1;
                chk_addr_next  = addr_reg[AW-1:0];
                addr_next      = addr_reg + XW'(1);
            end
            else
            begin
                chk_valid_next = 1'b0;
            end

            if (chk_valid_reg)
            begin
                if (chk_free)
                begin
                    if (run_reg == 11'd0)
                    begin
                        first_next = chk_addr_reg;
                    end
                    run_next = run_inc[10:0];
                end
                else
                begin
                    run_next = '0;
                end
            end

            if (hit)
            begin
                addr_next      = XW'(hit_first);
                last_next      = chk_addr_reg;
                res_ok_next    = 1'b1;
                res_start_next = 10'(hit_first);
                chk_valid_next = 1'b0;
            end
        end

        if (cmd.push)
        begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_DATA_W'({res_start_reg, res_ok_reg});
        end
        else if (out_ready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_base_reg <= USER_BASE_RST;
            addr_reg      <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            user_base_reg <= user_base_next;
            addr_reg      <= addr_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg  <= chk_addr_next;
        run_reg       <= run_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        bad_reg       <= bad_next;
        owner_reg     <= owner_next;
        count_reg     <= count_next;
        res_ok_reg    <= res_ok_next;
        res_start_reg <= res_start_next;
        m_data_reg    <= m_data_next;
    end

    a_fill_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> (addr_reg[AW-1:0] <= last_reg) && (addr_reg < TOTAL_X))
        else $error("fill pointer left the allocated run");

    a_free_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_step |-> (addr_reg < TOTAL_X))
        else $error("release pointer past the end of the map");

    a_fail_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && !res_ok_reg) |-> (res_start_reg == 10'd0))
        else $error("failed request carries a nonzero start block");

    a_word_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(cmd.push))
        else $error("output word appeared without a push");

endmodule

`default_nettype wire

FILE: design/first_fit_block_allocator.sv
// First-fit allocator of contiguous blocks over an owner map of TOTAL_BLOCKS entries.
// After reset the map is swept to free, one block per cycle, and no request is taken
// until the sweep reaches the last block; configuration writes are taken at any time.
// One request is handled at a time. An allocate reads the map one block per cycle
// from its search base and on a hit writes the owner id one block per cycle. A free writes
// one block per cycle. The result sits in an output register, so the next request
// is accepted while a word waits on the output.
`default_nettype none

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int TOTAL_BLOCKS = DEF_TOTAL_BLOCKS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [9:0]            cfg_wdata,      // user_base
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // owner_id[15:0], is_realtime[16], block_count[27:17], has_block[28],
    // free_start[38:29], zero[39]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tuser,   // func
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata    // ok[0], start_block[10:1], zero[15:11]
);

    ffba_cmd_t    cmd;
    ffba_status_t status;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_func  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffba_datapath #(
        .TOTAL_BLOCKS (TOTAL_BLOCKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .in_func   (s_axis_tuser),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
